// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked only while the reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Property that is checked at every edge, the reset included.
`define ASSERT_PROP_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hdl/setint_pkg.sv -----
// Types and codes shared by the set intersection block.
`timescale 1ns / 1ps

package setint_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes of an input word.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ABSENT  = 3'd0,
        ST_NEW     = 3'd1,
        ST_SEEN    = 3'd2,
        ST_FULL    = 3'd3,
        ST_LOADED  = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_PROBE,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } t_task;

endpackage

// ----- hdl/setint_if.sv -----
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps

interface setint_in_if;
    import setint_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface setint_out_if;
    import setint_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  echo_value;
    logic [COUNT_W-1:0]         common_count;

    modport source (output valid, output status, output echo_value, output common_count,
                    input ready);
    modport sink   (input valid, input status, input echo_value, input common_count,
                    output ready);
endinterface

// ----- hdl/setint_front.sv -----
// Front stage: takes input words, decodes the operation and holds one task.
`timescale 1ns / 1ps

module setint_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    setint_in_if.sink            i_in,
    output logic                 o_task_valid,
    output setint_pkg::t_task    o_task,
    input  logic                 i_task_ready
);
    import setint_pkg::*;

    logic  r_valid;
    t_task r_task;
    t_task n_task;
    logic  take;

    assign i_in.ready   = !r_valid || i_task_ready;
    assign take         = i_in.valid && i_in.ready;
    assign o_task_valid = r_valid;
    assign o_task       = r_task;

    always_comb begin
        n_task.value = i_in.value;
        case (i_in.operation)
            OP_CLEAR: n_task.cmd = CMD_CLEAR;
            OP_LOAD:  n_task.cmd = CMD_LOAD;
            OP_PROBE: n_task.cmd = CMD_PROBE;
            default:  n_task.cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_task_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_task <= n_task;
        end
    end

endmodule

// ----- hdl/setint_queue.sv -----
// Short task queue between the front stage and the execution stage.
`timescale 1ns / 1ps

module setint_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  setint_pkg::t_task    i_task,
    output logic                 o_ready,
    output logic                 o_valid,
    output setint_pkg::t_task    o_task,
    input  logic                 i_ready
);
    import setint_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_task          r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_fill;
    logic           push;
    logic           pop;

    assign o_ready = (r_fill != CW'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_task  = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_task;
        end
    end

endmodule

// ----- hdl/setint_back.sv -----
// Execution stage: reference store, emitted flags, scan sequencer and result register.
`timescale 1ns / 1ps

module setint_back #(
    parameter int SET_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_task_valid,
    input  setint_pkg::t_task    i_task,
    output logic                 o_task_ready,
    setint_out_if.source         o_res
);
    import setint_pkg::*;

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);

    // Each entry carries a flag that marks the element as already reported.
    // Only the first matching entry of a value is ever flagged, so the flags
    // stand for the distinct common elements found so far.
    typedef struct packed {
        logic                       emitted;
        logic signed [VALUE_W-1:0]  value;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_entry                     r_mem [SET_DEPTH];
    t_entry                     r_rd_data;
    t_state                     r_state,     n_state;
    logic [CW-1:0]              r_ref_count, n_ref_count;
    logic [CW-1:0]              r_total,     n_total;
    logic [CW-1:0]              r_issue,     n_issue;
    logic signed [VALUE_W-1:0]  r_value,     n_value;
    logic                       r_chk_vld;
    logic [AW-1:0]              r_chk_idx;
    logic                       r_out_valid, n_out_valid;
    t_status                    r_status,    n_status;
    logic signed [VALUE_W-1:0]  r_echo,      n_echo;
    logic [COUNT_W-1:0]         r_count,     n_count;

    logic           out_free;
    logic           take;
    logic           rd_en;
    logic           hit;
    logic           last;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    t_entry         wr_data;

    assign out_free     = !r_out_valid || o_res.ready;
    assign o_task_ready = (r_state == S_IDLE) && out_free;
    assign take         = i_task_valid && o_task_ready;
    assign rd_en        = (r_state == S_SCAN) && (r_issue < r_ref_count);
    assign hit          = r_chk_vld && (r_rd_data.value == r_value);
    assign last         = r_chk_vld && (CW'(r_chk_idx) == r_ref_count - CW'(1));

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.echo_value   = r_echo;
    assign o_res.common_count = r_count;

    always_comb begin
        n_state     = r_state;
        n_ref_count = r_ref_count;
        n_total     = r_total;
        n_issue     = r_issue;
        n_value     = r_value;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_echo      = r_echo;
        n_count     = r_count;
        wr_en       = 1'b0;
        wr_addr     = r_ref_count[AW-1:0];
        wr_data     = '{emitted: 1'b0, value: i_task.value};

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_value     = i_task.value;
                    n_echo      = i_task.value;
                    n_out_valid = 1'b1;
                    n_count     = COUNT_W'(r_total);
                    case (i_task.cmd)
                        CMD_CLEAR: begin
                            n_ref_count = '0;
                            n_total     = '0;
                            n_status    = ST_CLEARED;
                            n_count     = '0;
                        end
                        CMD_LOAD: begin
                            if (r_ref_count == CW'(SET_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                n_ref_count = r_ref_count + 1'b1;
                                n_status    = ST_LOADED;
                            end
                        end
                        CMD_PROBE: begin
                            n_status = ST_ABSENT;
                            if (r_ref_count != '0) begin
                                // The result is written when the scan ends.
                                n_out_valid = 1'b0;
                                n_issue     = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_ABSENT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_issue = r_issue + 1'b1;
                end
                if (hit) begin
                    n_out_valid = 1'b1;
                    n_echo      = r_value;
                    n_state     = S_IDLE;
                    if (r_rd_data.emitted || (r_total == CW'(SET_DEPTH))) begin
                        n_status = ST_SEEN;
                        n_count  = COUNT_W'(r_total);
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = r_chk_idx;
                        wr_data  = '{emitted: 1'b1, value: r_value};
                        n_total  = r_total + 1'b1;
                        n_status = ST_NEW;
                        n_count  = COUNT_W'(r_total + 1'b1);
                    end
                end else if (last) begin
                    n_out_valid = 1'b1;
                    n_echo      = r_value;
                    n_status    = ST_ABSENT;
                    n_count     = COUNT_W'(r_total);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref_count <= '0;
            r_total     <= '0;
            r_issue     <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref_count <= n_ref_count;
            r_total     <= n_total;
            r_issue     <= n_issue;
            r_chk_vld   <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_status  <= n_status;
        r_echo    <= n_echo;
        r_count   <= n_count;
        r_chk_idx <= r_issue[AW-1:0];
    end

    // Reference store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_issue[AW-1:0]];
        end
    end

endmodule

// ----- hdl/set_intersection_unique_top.sv -----
// Top level of the deduplicated set intersection block.
`timescale 1ns / 1ps

// Every input word gives exactly one result word, in order. A decode stage and a
// two-entry task queue sit in front of the execution stage, so input words keep
// being taken while a result waits in the output register. In the execution stage
// a clear, a load or an unused operation is answered without a scan. A probe walks
// the reference store through its single read port, one entry per cycle, and stops
// at the first match; when the store is empty it is answered without a scan. Each
// stored element carries a flag that marks it as already reported, which is how
// repeated probes are recognised.

module set_intersection_unique_top #(
    parameter int SET_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    setint_in_if.sink     i_in,
    setint_out_if.source  o_res
);
    import setint_pkg::*;

    logic  front_valid;
    t_task front_task;
    logic  front_ready;
    logic  queue_valid;
    t_task queue_task;
    logic  queue_ready;

    setint_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_task_valid (front_valid),
        .o_task       (front_task),
        .i_task_ready (front_ready)
    );

    setint_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_task  (front_task),
        .o_ready (front_ready),
        .o_valid (queue_valid),
        .o_task  (queue_task),
        .i_ready (queue_ready)
    );

    setint_back #(
        .SET_DEPTH (SET_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (queue_valid),
        .i_task       (queue_task),
        .o_task_ready (queue_ready),
        .o_res        (o_res)
    );

endmodule

// ----- hdl/setint_checker.sv -----
// Port-level checks on the set intersection block, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module setint_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [setint_pkg::STATUS_W-1:0]    i_status,
    input logic [setint_pkg::VALUE_W-1:0]     i_echo_value,
    input logic [setint_pkg::COUNT_W-1:0]     i_count
);
    import setint_pkg::*;

    logic                                   stalled;
    logic                                   cleared_word;
    logic                                   new_word;
    logic [STATUS_W+VALUE_W+COUNT_W-1:0]    payload;

    assign stalled      = i_out_valid && !i_out_ready;
    assign cleared_word = i_out_valid && (i_status == 3'(ST_CLEARED));
    assign new_word     = i_out_valid && (i_status == 3'(ST_NEW));
    assign payload      = {i_status, i_echo_value, i_count};

    // A held result word keeps its payload until it is taken.
    `ASSERT_PROP(a_hold, i_clk, i_rst_n, stalled |=> (i_out_valid && $stable(payload)))
    // No result word is offered straight after reset.
    `ASSERT_PROP_NR(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)
    // Status codes stay within the defined set.
    `ASSERT_PROP(a_status_range, i_clk, i_rst_n, i_out_valid |-> (i_status <= 3'(ST_CLEARED)))
    // A clear always reports an empty result store.
    `ASSERT_PROP(a_clear_count, i_clk, i_rst_n, cleared_word |-> (i_count == '0))
    // A newly found common element leaves the result store non-empty.
    `ASSERT_PROP(a_new_count, i_clk, i_rst_n, new_word |-> (i_count != '0))

endmodule

bind set_intersection_unique_top setint_checker u_setint_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_echo_value (o_res.echo_value),
    .i_count      (o_res.common_count)
);

// ----- test/tb.sv -----
// Self-checking testbench for the deduplicated set intersection block.
`timescale 1ns / 1ps

module tb;
    import setint_pkg::*;

    localparam int SET_DEPTH   = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_LIMIT = 50;
    // The block answers this code without touching either store.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_status             status;
        logic [VALUE_W-1:0]  echo;
        logic [COUNT_W-1:0]  count;
    } outcome_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    setint_in_if  in_if ();
    setint_out_if res_if ();

    set_intersection_unique_top #(.SET_DEPTH(SET_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_res   (res_if.source)
    );

    // Shadow copy of both stores, advanced once per accepted word.
    logic [VALUE_W-1:0] ref_members [SET_DEPTH];
    logic [VALUE_W-1:0] common_members [SET_DEPTH];
    int                 ref_used;
    int                 common_used;

    outcome_t awaited_results [$];
    outcome_t want;
    int       error_count;
    int       cycle_count;
    int       src_idle_pct;
    int       snk_stall_pct;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic outcome_t intersect_step(input logic [1:0] op,
                                                input logic [VALUE_W-1:0] v);
        outcome_t res;
        bit       in_ref;
        bit       in_common;
        res.status = ST_ABSENT;
        res.echo   = v;
        case (op)
            OP_CLEAR: begin
                ref_used    = 0;
                common_used = 0;
                res.status  = ST_CLEARED;
            end
            OP_LOAD: begin
                if (ref_used >= SET_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ref_members[ref_used] = v;
                    ref_used++;
                    res.status = ST_LOADED;
                end
            end
            OP_PROBE: begin
                in_ref    = 1'b0;
                in_common = 1'b0;
                for (int i = 0; i < ref_used; i++)
                    if (ref_members[i] == v) in_ref = 1'b1;
                for (int i = 0; i < common_used; i++)
                    if (common_members[i] == v) in_common = 1'b1;
                if (!in_ref) begin
                    res.status = ST_ABSENT;
                end else if (in_common || common_used >= SET_DEPTH) begin
                    // A full result store is treated as already reported.
                    res.status = ST_SEEN;
                end else begin
                    common_members[common_used] = v;
                    common_used++;
                    res.status = ST_NEW;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(common_used);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Sends one word, with random idle cycles in front of it, and records its outcome.
    task automatic send_word(input logic [1:0] op, input logic [VALUE_W-1:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid     = 1'b0;
            in_if.operation = 2'($urandom_range(3));
            in_if.value     = $urandom;
            @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.operation = op;
        in_if.value     = v;
        do @(posedge i_clk); while (!in_if.ready);
        awaited_results.push_back(intersect_step(op, v));
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return VALUE_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // The receiver stalls at random; it is sampled at the rising edge.
    always @(negedge i_clk)
        res_if.ready = ($urandom_range(99) >= snk_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word status %0d value %h count %0d",
                                res_if.status, res_if.echo_value, res_if.common_count));
            end else begin
                want = awaited_results.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d (value %h)",
                                    res_if.status, want.status, want.echo));
                if (res_if.echo_value !== want.echo)
                    report_mismatch($sformatf("echo_value %h, wanted %h",
                                    res_if.echo_value, want.echo));
                if (res_if.common_count !== want.count)
                    report_mismatch($sformatf("common_count %0d, wanted %0d (value %h)",
                                    res_if.common_count, want.count, want.echo));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", awaited_results.size());
            $display("tb: errors");
            $finish;
        end
    end

    // Extremes, every operation, duplicates, repeats and a clear on an empty store.
    task automatic test_directed_cases();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_word(OP_PROBE, 32'h1234_5678);
        send_word(OP_UNUSED, 32'hDEAD_BEEF);
        send_word(OP_LOAD, 32'h8000_0000);
        send_word(OP_LOAD, 32'h7FFF_FFFF);
        send_word(OP_LOAD, 32'h0000_0000);
        send_word(OP_LOAD, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 32'h7FFF_FFFF);
        send_word(OP_LOAD, 32'h5A5A_5A5A);
        send_word(OP_PROBE, 32'h8000_0000);
        send_word(OP_PROBE, 32'h8000_0000);
        send_word(OP_PROBE, 32'h7FFF_FFFF);
        send_word(OP_PROBE, 32'h7FFF_FFFF);
        send_word(OP_PROBE, 32'h0000_0000);
        send_word(OP_PROBE, 32'hFFFF_FFFF);
        send_word(OP_PROBE, 32'h0000_0001);
        send_word(OP_PROBE, 32'hA5A5_A5A5);
        send_word(OP_PROBE, 32'h5A5A_5A5A);
        send_word(OP_UNUSED, 32'h8000_0000);
        send_word(OP_CLEAR, 32'hFFFF_FFFF);
        send_word(OP_PROBE, 32'h8000_0000);
        send_word(OP_CLEAR, 32'h0000_0000);
    endtask

    // Fills the reference store, overflows it and probes both ends of it.
    task automatic test_reference_overflow();
        logic [VALUE_W-1:0] first_v;
        logic [VALUE_W-1:0] last_v;
        first_v = $urandom;
        last_v  = first_v;
        send_word(OP_CLEAR, 32'h0);
        send_word(OP_LOAD, first_v);
        for (int i = 1; i < SET_DEPTH; i++) begin
            last_v = $urandom;
            send_word(OP_LOAD, last_v);
        end
        send_word(OP_LOAD, 32'h8000_0000);
        send_word(OP_LOAD, 32'h7FFF_FFFF);
        send_word(OP_PROBE, last_v);
        send_word(OP_PROBE, first_v);
        send_word(OP_PROBE, 32'h8000_0000);
        send_word(OP_PROBE, last_v);
    endtask

    // Mostly clear, load, probe rounds with random content; the rest is noise,
    // rounds without a clear and clears in the middle of the probes.
    task automatic test_random_rounds(input int src_pct, input int snk_pct, input int quota);
        logic [VALUE_W-1:0] members [$];
        logic [VALUE_W-1:0] probed [$];
        logic [VALUE_W-1:0] v;
        int                 sent;
        int                 n_load;
        int                 n_probe;
        int                 r;
        bit                 first;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent  = 0;
        first = 1'b1;
        while (sent < quota) begin
            if (first || $urandom_range(99) >= 15) begin
                send_word(OP_CLEAR, pick_value());
                members.delete();
                probed.delete();
                sent++;
            end
            if (first)
                n_load = $urandom_range(SET_DEPTH, SET_DEPTH + 4);
            else begin
                r = $urandom_range(99);
                n_load = (r < 70) ? $urandom_range(1, 12) :
                         (r < 92) ? $urandom_range(13, 40) :
                                    $urandom_range(SET_DEPTH - 4, SET_DEPTH + 4);
            end
            first = 1'b0;
            for (int i = 0; i < n_load; i++) begin
                if (members.size() > 0 && $urandom_range(99) < 15)
                    v = members[$urandom_range(members.size() - 1)];
                else
                    v = pick_value();
                send_word(OP_LOAD, v);
                if (members.size() < SET_DEPTH) members.push_back(v);
                sent++;
            end
            n_probe = $urandom_range(n_load, 2 * n_load + 2);
            for (int i = 0; i < n_probe; i++) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    send_word(OP_UNUSED, $urandom);
                    continue;
                end
                if (r < 10) begin
                    send_word(OP_CLEAR, $urandom);
                    members.delete();
                    probed.delete();
                end else if (r < 15) begin
                    v = pick_value();
                    send_word(OP_LOAD, v);
                    if (members.size() < SET_DEPTH) members.push_back(v);
                end else begin
                    if (r < 55 && members.size() > 0)
                        v = members[$urandom_range(members.size() - 1)];
                    else if (r < 75 && probed.size() > 0)
                        v = probed[$urandom_range(probed.size() - 1)];
                    else if (r < 85 && members.size() > 0)
                        v = members[$urandom_range(members.size() - 1)]
                            ^ (32'h1 << $urandom_range(31));
                    else
                        v = pick_value();
                    send_word(OP_PROBE, v);
                    probed.push_back(v);
                end
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_CLEAR;
        in_if.value     = '0;
        res_if.ready    = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        error_count     = 0;
        cycle_count     = 0;
        ref_used        = 0;
        common_used     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_reference_overflow();
        test_random_rounds(0, 0, 365);
        test_random_rounds(48, 0, 365);
        test_random_rounds(0, 48, 365);
        test_random_rounds(8, 8, 365);

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SET_DEPTH + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/setint_pkg.sv
hdl/setint_if.sv
hdl/setint_front.sv
hdl/setint_queue.sv
hdl/setint_back.sv
hdl/set_intersection_unique_top.sv
hdl/setint_checker.sv
test/tb.sv
